@@ rtl/core/sig_pkg.sv @@
// Shared widths, register indexes and reset values of the strided index generator.
package sig_pkg;

  localparam int NumDims     = 4;
  localparam int ExtW        = 12;
  localparam int StepW       = 16;
  localparam int OffW        = 30;
  localparam int ProdW       = ExtW + StepW;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 16;
  localparam int RankDefault = 4;

  typedef logic [ExtW-1:0]  ext_t;
  typedef logic [StepW-1:0] step_t;
  typedef logic [OffW-1:0]  off_t;
  typedef logic [ProdW-1:0] prod_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegExtent0 = 3'd0,
    RegExtent1 = 3'd1,
    RegExtent2 = 3'd2,
    RegExtent3 = 3'd3,
    RegStep0   = 3'd4,
    RegStep1   = 3'd5,
    RegStep2   = 3'd6,
    RegStep3   = 3'd7
  } cfg_reg_t;

  localparam ext_t  ExtentReset    = 12'd1;
  localparam step_t StepReset      = 16'd0;
  localparam step_t StepInnerReset = 16'd1;

endpackage

@@ rtl/core/sig_if.sv @@
// Request and result channel interfaces of the strided index generator.
interface sig_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface sig_out_if
  import sig_pkg::*;
;
  logic valid;
  logic ready;
  off_t offset;
  logic last;

  modport source (output valid, output offset, output last, input ready);
  modport sink   (input valid, input offset, input last, output ready);
endinterface

@@ rtl/core/strided_index_generator.sv @@
// Strided index generator: row-major walk with per-dimension strides.
// Pipeline: walk, multiply and sum stages, each registered, from request transaction to result valid.
// Throughput: one transaction per cycle while the result side is ready; an empty stage fills while a later one stalls.
// The rate is set by the combinational coordinate carry in the walk stage.
// Reset (synchronous, active low): clears coordinates and pipeline valids,
// extents to 1, strides to 0 except the innermost stride to 1.
module strided_index_generator
  import sig_pkg::*;
#(
  parameter int RANK = RankDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  sig_in_if.sink              in_tx,
  sig_out_if.source           out_tx
);

  localparam int FirstActive = (RANK >= NumDims) ? 0 : ((RANK <= 0) ? NumDims : NumDims - RANK);

  ext_t  ext_r  [NumDims];
  step_t step_r [NumDims];
  ext_t  coord_r [NumDims];
  ext_t  coord_nxt [NumDims];
  ext_t  cur [NumDims];
  logic  last0;

  logic  v1_r, v2_r, v3_r;
  ext_t  s1_coord_r [NumDims];
  logic  s1_last_r;
  prod_t s2_prod_r [NumDims];
  logic  s2_last_r;
  off_t  s3_off_r;
  logic  s3_last_r;

  logic  rdy1, rdy2, rdy3, in_fire;

  assign rdy3 = !v3_r || out_tx.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tx.ready = rdy1;
  assign in_fire = in_tx.valid && rdy1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < NumDims; d++) begin
        ext_r[d]  <= ExtentReset;
        step_r[d] <= StepReset;
      end
      step_r[NumDims-1] <= StepInnerReset;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        RegExtent0: ext_r[0]  <= cfg_wdata[ExtW-1:0];
        RegExtent1: ext_r[1]  <= cfg_wdata[ExtW-1:0];
        RegExtent2: ext_r[2]  <= cfg_wdata[ExtW-1:0];
        RegExtent3: ext_r[3]  <= cfg_wdata[ExtW-1:0];
        RegStep0:   step_r[0] <= cfg_wdata[StepW-1:0];
        RegStep1:   step_r[1] <= cfg_wdata[StepW-1:0];
        RegStep2:   step_r[2] <= cfg_wdata[StepW-1:0];
        RegStep3:   step_r[3] <= cfg_wdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  // walk: current position, last flag and next position
  always_comb begin
    logic carry;
    logic at_end [NumDims];
    ext_t lim;
    carry = 1'b1;
    last0 = 1'b1;
    for (int d = 0; d < NumDims; d++) begin
      cur[d] = (in_tx.restart || d < FirstActive) ? '0 : coord_r[d];
      lim = (ext_r[d] == '0) ? '0 : ext_r[d] - ext_t'(1);
      at_end[d] = (cur[d] >= lim);
      if (d >= FirstActive && !at_end[d]) last0 = 1'b0;
      coord_nxt[d] = cur[d];
    end
    for (int d = NumDims - 1; d >= 0; d--) begin
      if (d >= FirstActive && carry) begin
        if (at_end[d]) begin
          coord_nxt[d] = '0;
        end else begin
          coord_nxt[d] = cur[d] + ext_t'(1);
          carry = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < NumDims; d++) coord_r[d] <= '0;
    end else if (in_fire) begin
      for (int d = 0; d < NumDims; d++) coord_r[d] <= coord_nxt[d];
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tx.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int d = 0; d < NumDims; d++) s1_coord_r[d] <= cur[d];
      s1_last_r <= last0;
    end
    if (rdy2 && v1_r) begin
      for (int d = 0; d < NumDims; d++) begin
        s2_prod_r[d] <= (d < FirstActive) ? '0 : prod_t'(s1_coord_r[d]) * prod_t'(step_r[d]);
      end
      s2_last_r <= s1_last_r;
    end
    if (rdy3 && v2_r) begin
      s3_off_r  <= off_t'(s2_prod_r[0]) + off_t'(s2_prod_r[1])
                 + off_t'(s2_prod_r[2]) + off_t'(s2_prod_r[3]);
      s3_last_r <= s2_last_r;
    end
  end

  assign out_tx.valid  = v3_r;
  assign out_tx.offset = s3_off_r;
  assign out_tx.last   = s3_last_r;

  a_restart_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tx.restart) |=>
      (s1_coord_r[0] == '0 && s1_coord_r[1] == '0 && s1_coord_r[2] == '0 &&
       s1_coord_r[3] == '0))
    else $error("restart did not start the walk at the origin");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last0) |=>
      (coord_r[0] == '0 && coord_r[1] == '0 && coord_r[2] == '0 && coord_r[3] == '0))
    else $error("walk did not wrap after the final element");

  a_out_from_s2: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v3_r) |-> $past(v2_r))
    else $error("result valid without a product stage transaction");

endmodule

@@ dv/tb_top.sv @@
// Testbench for the strided index generator: directed and random walks checked against a predicted offset stream.
`timescale 1ns / 1ps

module tb_top;
  import sig_pkg::*;

  localparam int LongHold = 48;

  class walk_scoreboard;
    typedef struct packed {
      off_t offset;
      logic last;
    } walk_result_t;

    int           lo;
    ext_t         extent [NumDims];
    step_t        stride [NumDims];
    ext_t         coord  [NumDims];
    walk_result_t pending_offsets [$];
    int unsigned  failures;

    function new(int rank);
      if (rank >= NumDims) lo = 0;
      else if (rank <= 0) lo = NumDims;
      else lo = NumDims - rank;
      for (int d = 0; d < NumDims; d++) begin
        extent[d] = ExtentReset;
        stride[d] = StepReset;
        coord[d]  = '0;
      end
      stride[NumDims-1] = StepInnerReset;
      failures = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] data);
      if (idx < RegStep0) extent[int'(idx)] = data[ExtW-1:0];
      else stride[int'(idx) - int'(RegStep0)] = data[StepW-1:0];
    endfunction

    function bit is_complete(int d);
      int unsigned e;
      e = (extent[d] == '0) ? 32'd1 : 32'(extent[d]);
      return (32'(coord[d]) + 32'd1) >= e;
    endfunction

    function void note_request(logic restart);
      walk_result_t r;
      r.offset = '0;
      r.last   = 1'b1;
      if (restart) begin
        for (int d = 0; d < NumDims; d++) coord[d] = '0;
      end
      for (int d = 0; d < lo; d++) coord[d] = '0;
      for (int d = lo; d < NumDims; d++) begin
        r.offset = off_t'(r.offset + off_t'(coord[d]) * off_t'(stride[d]));
        if (!is_complete(d)) r.last = 1'b0;
      end
      pending_offsets.insert(pending_offsets.size(), r);
      // advance innermost first, carry outward
      for (int d = NumDims - 1; d >= lo; d--) begin
        if (is_complete(d)) begin
          coord[d] = '0;
        end else begin
          coord[d] = coord[d] + 1'b1;
          break;
        end
      end
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(off_t offset, logic last);
      walk_result_t r;
      if (pending_offsets.size() == 0) begin
        flag($sformatf("unexpected result offset %0d last %0b", offset, last));
        return;
      end
      r = pending_offsets.pop_front();
      if (offset !== r.offset)
        flag($sformatf("offset mismatch: expected %0d, got %0d", r.offset, offset));
      if (last !== r.last)
        flag($sformatf("last mismatch: expected %0b, got %0b", r.last, last));
    endfunction

    function int pending();
      return pending_offsets.size();
    endfunction

    function void finish_check();
      if (pending_offsets.size() != 0)
        flag($sformatf("%0d results never arrived", pending_offsets.size()));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  sig_in_if  in_tx ();
  sig_out_if out_tx ();

  walk_scoreboard sb;
  int             src_mode;
  int             snk_mode;
  bit             stall_pending;

  strided_index_generator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tx     (in_tx),
    .out_tx    (out_tx)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb_top: errors");
    $finish;
  end

  function automatic int pick_gap(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 1) begin
      if (r < 80) return 0;
      if (r < 97) return $urandom_range(1, 2);
      return $urandom_range(10, 40);
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 4);
    return $urandom_range(12, 40);
  endfunction

  task automatic send_request(input logic restart);
    int gap;
    gap = pick_gap(src_mode);
    if (gap > 0) begin
      in_tx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tx.valid   <= 1'b1;
    in_tx.restart <= restart;
    forever begin
      @(negedge clk);
      if (in_tx.ready) begin
        sb.note_request(in_tx.restart);
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tx.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_field(input cfg_reg_t idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CfgDataW-1:0] ext_word(int e);
    return {4'($urandom_range(0, 15)), ext_t'(e)};
  endfunction

  task automatic load_walk(input int e0, e1, e2, e3, s0, s1, s2, s3);
    write_field(RegExtent0, ext_word(e0));
    write_field(RegExtent1, ext_word(e1));
    write_field(RegExtent2, ext_word(e2));
    write_field(RegExtent3, ext_word(e3));
    write_field(RegStep0, step_t'(s0));
    write_field(RegStep1, step_t'(s1));
    write_field(RegStep2, step_t'(s2));
    write_field(RegStep3, step_t'(s3));
    end_writes();
  endtask

  function automatic int pick_extent();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 4095;
    if (r <= 3) return $urandom_range(1, 4095);
    return $urandom_range(1, 4);
  endfunction

  function automatic step_t pick_step();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return step_t'($urandom);
  endfunction

  task automatic random_phase(input int ph);
    bit full;
    int restart_mode;
    int count;
    logic r;
    full = (ph == 0) || ($urandom_range(0, 2) == 0);
    for (int i = 0; i < 2 * NumDims; i++) begin
      if (full || $urandom_range(0, 2) != 0) begin
        if (i < NumDims) write_field(cfg_reg_t'(i), ext_word(pick_extent()));
        else write_field(cfg_reg_t'(i), pick_step());
      end
    end
    end_writes();
    src_mode     = $urandom_range(0, 2);
    snk_mode     = $urandom_range(0, 2);
    restart_mode = $urandom_range(0, 2);
    if (ph == 3) begin
      src_mode      = 0;
      stall_pending = 1'b1;
    end
    count = $urandom_range(60, 120);
    for (int k = 0; k < count; k++) begin
      if (k == 0) r = ($urandom_range(0, 2) != 0);
      else if (restart_mode == 0) r = 1'b0;
      else if (restart_mode == 1) r = ($urandom_range(0, 39) == 0);
      else r = ($urandom_range(0, 3) == 0);
      send_request(r);
    end
    drain();
  endtask

  // result side: random back-pressure, one long hold-off on request
  initial begin
    int hold_left;
    int gap_left;
    hold_left    = 0;
    gap_left     = 0;
    out_tx.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tx.ready <= 1'b0;
        hold_left--;
      end else if (stall_pending) begin
        stall_pending = 1'b0;
        hold_left = LongHold - 1;
        out_tx.ready <= 1'b0;
      end else if (gap_left > 0) begin
        out_tx.ready <= 1'b0;
        gap_left--;
      end else begin
        gap_left = pick_gap(snk_mode);
        out_tx.ready <= (gap_left == 0);
        if (gap_left > 0) gap_left--;
      end
      @(negedge clk);
      if (out_tx.valid && out_tx.ready) sb.check_result(out_tx.offset, out_tx.last);
    end
  end

  initial begin
    sb            = new(RankDefault);
    src_mode      = 0;
    snk_mode      = 0;
    stall_pending = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = RegExtent0;
    cfg_wdata     = '0;
    in_tx.valid   = 1'b0;
    in_tx.restart = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: single-element walk
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    drain();

    // full walk of a 2x1x3x2 tensor with the largest strides on dimensions 0, 2 and 3, then wrap
    load_walk(2, 1, 3, 2, 65535, 0, 65535, 65535);
    send_request(1'b1);
    for (int k = 0; k < 12; k++) send_request(1'b0);
    drain();

    // zero extents behave as one
    load_walk(0, 0, 0, 2, 1234, 4321, 777, 65535);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    drain();

    // shrink the inner extent below the current coordinate
    load_walk(1, 1, 1, 4095, 0, 0, 0, 65535);
    send_request(1'b1);
    for (int k = 0; k < 4; k++) send_request(1'b0);
    drain();
    write_field(RegExtent3, ext_word(3));
    end_writes();
    send_request(1'b0);
    send_request(1'b0);
    drain();

    for (int ph = 0; ph < 9; ph++) random_phase(ph);

    repeat (8) @(posedge clk);
    sb.finish_check();
    if (sb.failures == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sig_pkg.sv
rtl/core/sig_if.sv
rtl/core/strided_index_generator.sv
dv/tb_top.sv
